>>> src/gbl_pkg.sv
// gbl_pkg: shared constants, kernel weights and types of the 5x5 RGB blur.
// No dependencies; used by all sources but gbl_if and gbl_line_store.
package gbl_pkg;

  // Default line and frame limits
  localparam int GBL_MAX_WIDTH  = 2048;
  localparam int GBL_MAX_HEIGHT = 4096;

  // Register reset values and indexes
  localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic        REG_FRAME_WIDTH    = 1'b0;
  localparam logic        REG_FRAME_HEIGHT   = 1'b1;

  // Request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Distinct kernel weights in thousandths
  localparam logic [7:0] W_CORNER = 8'd3;
  localparam logic [7:0] W_EDGE   = 8'd13;
  localparam logic [7:0] W_AXIS2  = 8'd22;
  localparam logic [7:0] W_DIAG1  = 8'd59;
  localparam logic [7:0] W_AXIS1  = 8'd97;
  localparam logic [7:0] W_CENTER = 8'd159;

  // Divide by 1000: multiply by ceil(2^28/1000), keep bits above 28
  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam int          RECIP_SHIFT = 28;

  // One channel of the 5x5 window, [row][column]
  typedef logic [4:0][4:0][7:0] chan_win_t;

  // Per-output control carried down the pipeline
  typedef struct packed {
    logic border;
    logic frame_end;
  } ctl_t;

endpackage

>>> src/gbl_if.sv
// gbl_if: valid/ready stream interfaces for pixel requests and filtered results.
// No dependencies.
interface gbl_pix_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, req_type, red, green, blue, input ready);
  modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface gbl_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

>>> src/gaussian_blur_5x5_rgb.sv
// gaussian_blur_5x5_rgb: top level, counters, window, lanes and config port.
// Depends on gbl_pkg, gbl_if, gbl_line_store, gbl_lane and gbl_merge.
//
// Streaming 5x5 Gaussian blur of RGB pixels in raster order. One transaction
// is taken every clock while the result side keeps up. An output is
// released by the transaction of the pixel 2*width+2 positions later (or a
// flush once the frame input is complete) and then passes the stage 1,
// window, lane and merge registers, held while the result side stalls.
// The rate is set by the single-port line memories, read and written once per
// pixel. The two-pixel border is emitted as zero. The line memories need no
// clearing after reset. A register write restarts the frame; the input is held
// off in the cycle after it while the frame dimensions settle.
module gaussian_blur_5x5_rgb #(
  parameter int MAX_WIDTH  = gbl_pkg::GBL_MAX_WIDTH,
  parameter int MAX_HEIGHT = gbl_pkg::GBL_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  gbl_pix_if.sink     pixels,
  gbl_res_if.source   results
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int TW = WW + HW;

  // Configuration registers
  logic [11:0] frame_width;
  logic [12:0] frame_height;
  logic        cfg_wr;
  logic        settle;
  logic [31:0] fw32, fh32;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [TW-1:0] total, thr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gbl_pkg::FRAME_WIDTH_RESET;
      frame_height <= gbl_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        gbl_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[11:0];
        gbl_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gbl_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      gbl_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:                   prdata = 32'd0;
    endcase
  end

  // Saturate dimensions and precompute frame size and release distance
  always_comb begin
    fw32 = 32'(frame_width);
    fh32 = 32'(frame_height);
    if (fw32 == 32'd0) fw32 = 32'd1;
    if (fw32 > 32'(MAX_WIDTH)) fw32 = 32'(MAX_WIDTH);
    if (fh32 == 32'd0) fh32 = 32'd1;
    if (fh32 > 32'(MAX_HEIGHT)) fh32 = 32'(MAX_HEIGHT);
    eff_w = WW'(fw32);
    eff_h = HW'(fh32);
  end

  always_ff @(posedge clk) begin
    total <= TW'(eff_w) * TW'(eff_h);
    thr   <= (TW'(eff_w) << 1) + TW'(2);
  end

  // Hold off input until the derived values follow a write
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_wr;
    end
  end

  // Position counters
  logic [CW-1:0] in_col, ocol;
  logic [1:0]    line;
  logic [RW-1:0] orow;
  logic [TW-1:0] recv, out_pos, recv_inc;
  logic          acc, take0, emit0, border0, fe0, col_last, ocol_last;
  logic          r1, r2, r3, r4, r5, r6;

  assign acc       = pixels.valid && pixels.ready;
  assign take0     = (pixels.req_type == gbl_pkg::REQ_PIXEL) && (recv < total);
  assign recv_inc  = recv + TW'(take0);
  assign emit0     = take0 ? ((recv_inc - out_pos) > thr)
                           : ((recv >= total) && (out_pos < total));
  assign border0   = !((orow >= RW'(2)) && ((HW + 1)'(orow) + (HW + 1)'(3) <= (HW + 1)'(eff_h))
                    && (ocol >= CW'(2)) && ((WW + 1)'(ocol) + (WW + 1)'(3) <= (WW + 1)'(eff_w)));
  assign fe0       = (out_pos + TW'(1)) == total;
  assign col_last  = (WW'(in_col) + WW'(1)) == eff_w;
  assign ocol_last = (WW'(ocol) + WW'(1)) == eff_w;
  assign pixels.ready = r1 && !settle;

  // Advance input and output positions; restart on write or frame end
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col  <= '0;
      line    <= '0;
      recv    <= '0;
      out_pos <= '0;
      orow    <= '0;
      ocol    <= '0;
    end else if (acc) begin
      if (emit0 && fe0) begin
        in_col  <= '0;
        line    <= '0;
        recv    <= '0;
        out_pos <= '0;
        orow    <= '0;
        ocol    <= '0;
      end else begin
        if (take0) begin
          recv <= recv_inc;
          if (col_last) begin
            in_col <= '0;
            line   <= line + 2'd1;
          end else begin
            in_col <= in_col + CW'(1);
          end
        end
        if (emit0) begin
          out_pos <= out_pos + TW'(1);
          if (ocol_last) begin
            ocol <= '0;
            orow <= orow + RW'(1);
          end else begin
            ocol <= ocol + CW'(1);
          end
        end
      end
    end
  end

  // Line memories read the column of the arriving pixel
  logic [3:0][23:0] line_rd;
  logic [23:0]      pix0;

  assign pix0 = {pixels.red, pixels.green, pixels.blue};

  gbl_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .en      (acc && take0),
    .addr    (in_col),
    .wr_line (line),
    .wdata   (pix0),
    .rdata   (line_rd)
  );

  // Stage 1: accepted transaction waiting for line data
  logic          v1, take1, emit1;
  gbl_pkg::ctl_t ctl1, ctl2, ctl3, ctl4, ctl5;
  logic [23:0]   pix1;
  logic [1:0]    line1;
  logic          v2, v3, v4, v5;

  assign r1 = !v1 || r2;
  assign r2 = !v2 || r3;
  assign r3 = !v3 || r4;
  assign r4 = !v4 || r5;
  assign r5 = !v5 || r6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= acc && (take0 || emit0);
      if (r2) v2 <= v1 && emit1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      take1 <= take0;
      emit1 <= emit0;
      ctl1  <= '{border: border0, frame_end: fe0};
      pix1  <= pix0;
      line1 <= line;
    end
    if (r2) ctl2 <= ctl1;
    if (r3) ctl3 <= ctl2;
    if (r4) ctl4 <= ctl3;
    if (r5) ctl5 <= ctl4;
  end

  // Window: shift left, new column from the lines and the current pixel
  logic [4:0][4:0][23:0] win;

  always_ff @(posedge clk) begin
    if (v1 && take1 && r2) begin
      for (int j = 0; j < 5; j++) begin
        for (int i = 0; i < 4; i++) begin
          win[j][i] <= win[j][i + 1];
        end
      end
      for (int k = 0; k < 4; k++) begin
        win[k][4] <= line_rd[2'(line1 + 2'(k))];
      end
      win[4][4] <= pix1;
    end
  end

  // Channel lanes: red, green, blue
  logic [2:0][7:0] lane_result;

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_lane
      gbl_pkg::chan_win_t cwin;
      always_comb begin
        for (int j = 0; j < 5; j++) begin
          for (int i = 0; i < 5; i++) begin
            cwin[j][i] = win[j][i][8 * (2 - c) +: 8];
          end
        end
      end
      gbl_lane u_lane (
        .clk    (clk),
        .en_grp (r3),
        .en_sum (r4),
        .en_div (r5),
        .win    (cwin),
        .result (lane_result[c])
      );
    end
  endgenerate

  gbl_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v5),
    .in_ready    (r6),
    .ctl         (ctl5),
    .lane_result (lane_result),
    .res         (results)
  );

  // Outputs never run ahead of received pixels
  a_out_behind: assert property (@(posedge clk) disable iff (rst)
    out_pos <= recv) else $error("output position passed input position");

  // Frame end restarts both counters
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    acc && emit0 && fe0 && !cfg_wr |=> (recv == '0) && (out_pos == '0))
    else $error("counters not cleared after frame end");

  // Column counters stay inside the row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    !settle |-> (WW'(in_col) < eff_w) && (WW'(ocol) < eff_w))
    else $error("column counter out of range");

  // A result is only produced after a transaction released it
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(v2) |-> $past(v1 && emit1))
    else $error("window stage filled without a released output");

endmodule

>>> src/gbl_line_store.sv
// gbl_line_store: four line memories of MAX_WIDTH pixels, one write and one
// registered read per line in a cycle. Depends on nothing.
module gbl_line_store #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  logic [1:0]                   wr_line,
  input  logic [23:0]                  wdata,
  output logic [3:0][23:0]             rdata
);

  genvar b;
  generate
    for (b = 0; b < 4; b++) begin : g_line
      logic [23:0] mem [MAX_WIDTH];
      // Write this line when selected, read old contents at the same column
      always_ff @(posedge clk) begin
        if (en) begin
          if (wr_line == 2'(b)) begin
            mem[addr] <= wdata;
          end
          rdata[b] <= mem[addr];
        end
      end
    end
  endgenerate

endmodule

>>> src/gbl_lane.sv
// gbl_lane: one color channel of the 5x5 kernel, three pipeline stages:
// symmetric group sums, weighted sum, divide by 1000. Depends on gbl_pkg.
module gbl_lane (
  input  logic              clk,
  input  logic              en_grp,
  input  logic              en_sum,
  input  logic              en_div,
  input  gbl_pkg::chan_win_t win,
  output logic [7:0]        result
);

  logic [9:0]  g_corner, g_axis2, g_diag1, g_axis1;
  logic [10:0] g_edge;
  logic [7:0]  g_center;
  logic [17:0] wsum;
  logic [17:0] wsum_next;
  logic [36:0] prod;

  // Sum pixels that share a weight
  always_ff @(posedge clk) begin
    if (en_grp) begin
      g_corner <= 10'(win[0][0]) + 10'(win[0][4]) + 10'(win[4][0]) + 10'(win[4][4]);
      g_edge   <= 11'(win[0][1]) + 11'(win[0][3]) + 11'(win[1][0]) + 11'(win[1][4])
                + 11'(win[3][0]) + 11'(win[3][4]) + 11'(win[4][1]) + 11'(win[4][3]);
      g_axis2  <= 10'(win[0][2]) + 10'(win[2][0]) + 10'(win[2][4]) + 10'(win[4][2]);
      g_diag1  <= 10'(win[1][1]) + 10'(win[1][3]) + 10'(win[3][1]) + 10'(win[3][3]);
      g_axis1  <= 10'(win[1][2]) + 10'(win[2][1]) + 10'(win[2][3]) + 10'(win[3][2]);
      g_center <= win[2][2];
    end
  end

  // Apply weights
  always_comb begin
    wsum_next = 18'(g_corner) * 18'(gbl_pkg::W_CORNER)
              + 18'(g_edge)   * 18'(gbl_pkg::W_EDGE)
              + 18'(g_axis2)  * 18'(gbl_pkg::W_AXIS2)
              + 18'(g_diag1)  * 18'(gbl_pkg::W_DIAG1)
              + 18'(g_axis1)  * 18'(gbl_pkg::W_AXIS1)
              + 18'(g_center) * 18'(gbl_pkg::W_CENTER);
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      wsum <= wsum_next;
    end
  end

  // Truncating divide by 1000 through the reciprocal
  assign prod = 37'(wsum) * 37'(gbl_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    if (en_div) begin
      result <= prod[gbl_pkg::RECIP_SHIFT +: 8];
    end
  end

endmodule

>>> src/gbl_merge.sv
// gbl_merge: combines the three lane results, forces the border to zero and
// holds the result transaction. Depends on gbl_pkg and gbl_if.
module gbl_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbl_pkg::ctl_t       ctl,
  input  logic [2:0][7:0]     lane_result,
  gbl_res_if.source           res
);

  assign in_ready = !res.valid || res.ready;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (in_ready) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      res.out_red   <= ctl.border ? 8'd0 : lane_result[0];
      res.out_green <= ctl.border ? 8'd0 : lane_result[1];
      res.out_blue  <= ctl.border ? 8'd0 : lane_result[2];
      res.frame_end <= ctl.frame_end;
    end
  end

endmodule

>>> bench/gbl_checker.sv
// gbl_checker: watches the pixel, result and register channels of the blur,
// predicts every filtered pixel and compares it. Depends on gbl_pkg and gbl_if.
`timescale 1ns / 1ps

module gbl_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  gbl_pix_if          pix,
  gbl_res_if          res,
  output int          fail_count,
  output int          pending
);

  localparam int LMAX = gbl_pkg::GBL_MAX_WIDTH;
  localparam int HMAX = gbl_pkg::GBL_MAX_HEIGHT;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } blur_px_t;

  // Kernel table in thousandths, [row][column]
  localparam int KW [5][5] = '{
    '{3, 13, 22, 13, 3},
    '{13, 59, 97, 59, 13},
    '{22, 97, 159, 97, 22},
    '{13, 59, 97, 59, 13},
    '{3, 13, 22, 13, 3}
  };

  logic [11:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] line_mem [0:4*LMAX-1];
  logic [23:0] win [5][5];
  int unsigned col_pos, row_pos, out_pos;
  blur_px_t    blurred_q[$];

  assign pending = blurred_q.size();

  function automatic int unsigned sat_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LMAX) w = LMAX;
    return w;
  endfunction

  function automatic int unsigned sat_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > HMAX) h = HMAX;
    return h;
  endfunction

  function automatic logic [7:0] blur_chan(int sh);
    int unsigned acc;
    acc = 0;
    for (int j = 0; j < 5; j++)
      for (int i = 0; i < 5; i++)
        acc += KW[j][i] * ((win[j][i] >> sh) & 8'hFF);
    return 8'(acc / 1000);
  endfunction

  task automatic restart();
    for (int j = 0; j < 5; j++)
      for (int i = 0; i < 5; i++)
        win[j][i] = '0;
    col_pos = 0;
    row_pos = 0;
    out_pos = 0;
  endtask

  // Shift the window, pull the column from the line stores, store the pixel
  task automatic shift_in(logic [23:0] px, int unsigned w);
    int unsigned c;
    logic [23:0] up [4];
    c = (col_pos >= LMAX) ? LMAX - 1 : col_pos;
    for (int k = 0; k < 4; k++)
      up[k] = line_mem[((row_pos + k) % 4) * LMAX + c];
    for (int j = 0; j < 5; j++)
      for (int i = 0; i < 4; i++)
        win[j][i] = win[j][i + 1];
    for (int k = 0; k < 4; k++)
      win[k][4] = up[k];
    win[4][4] = px;
    line_mem[(row_pos % 4) * LMAX + c] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
  endtask

  task automatic predict_blur(logic rq, logic [23:0] px);
    int unsigned w, h, total, got, r, c;
    logic emit;
    blur_px_t e;
    w = sat_width();
    h = sat_height();
    total = w * h;
    got = row_pos * w + col_pos;
    if (rq == gbl_pkg::REQ_PIXEL && got < total) begin
      shift_in(px, w);
      got++;
      emit = (got - out_pos) > (2 * w + 2);
    end else begin
      emit = (got >= total) && (out_pos < total);
    end
    if (emit) begin
      r = out_pos / w;
      c = out_pos % w;
      e = '0;
      if (r >= 2 && r + 3 <= h && c >= 2 && c + 3 <= w) begin
        e.r = blur_chan(16);
        e.g = blur_chan(8);
        e.b = blur_chan(0);
      end
      e.fe = (out_pos + 1 == total);
      out_pos++;
      if (e.fe) restart();
      blurred_q.push_back(e);
    end
  endtask

  // Follow register writes, predict on accepted pixels, compare results
  always @(posedge clk) begin
    blur_px_t e;
    if (rst) begin
      width_reg  = gbl_pkg::FRAME_WIDTH_RESET;
      height_reg = gbl_pkg::FRAME_HEIGHT_RESET;
      restart();
      blurred_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == gbl_pkg::REG_FRAME_HEIGHT) height_reg = pwdata[12:0];
        else width_reg = pwdata[11:0];
        restart();
      end
      if (pix.valid && pix.ready)
        predict_blur(pix.req_type, {pix.red, pix.green, pix.blue});
      if (res.valid && res.ready) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d fe=%0b", $time,
                   res.out_red, res.out_green, res.out_blue, res.frame_end);
          fail_count <= fail_count + 1;
        end else begin
          e = blurred_q.pop_front();
          if (e != {res.out_red, res.out_green, res.out_blue, res.frame_end}) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d fe=%0b, got r=%0d g=%0d b=%0d fe=%0b",
                     $time, e.r, e.g, e.b, e.fe,
                     res.out_red, res.out_green, res.out_blue, res.frame_end);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/tb.sv
// tb: stimulus and verdict for gaussian_blur_5x5_rgb; drives frames of many sizes,
// register writes and random stalls. Depends on gbl_pkg, gbl_if and gbl_checker.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          chk_fails, pending, bench_fails, idle_cycles, sent_px;
  logic        calm;

  gbl_pix_if pix_ch ();
  gbl_res_if res_ch ();

  gaussian_blur_5x5_rgb dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixels(pix_ch.sink), .results(res_ch.source)
  );

  gbl_checker chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .pix(pix_ch), .res(res_ch), .fail_count(chk_fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random stalls on the result side
  always @(negedge clk) begin
    int g;
    if (rst) begin
      res_ch.ready <= 1'b1;
    end else if (res_ch.ready) begin
      g = gap_len();
      if (g > 0) begin
        res_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Hold valid until the transaction; keep it high for a back-to-back item
  task automatic send_item(logic rq, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gp;
    gp = gap_len();
    @(negedge clk);
    if (gp > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gp) @(negedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.req_type <= rq;
    pix_ch.red      <= r;
    pix_ch.green    <= g;
    pix_ch.blue     <= b;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic send_rand(logic rq);
    send_item(rq, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic reg_check(logic [2:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= a;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata != d) begin
      $display("%0t: register %0d expected %0d, got %0d", $time, a, d, prdata);
      bench_fails++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // One frame: configure, stream pixels, then drain the trailing border. A nonzero
  // cut below the frame size stops the input early and leaves the frame unfinished.
  task automatic run_frame(int wr, int hr, int cut, int style);
    int w, h, total, n, tail;
    logic [7:0] v;
    settle();
    reg_write(3'd0, wr);
    reg_check(3'd0, wr);
    reg_write(3'd4, hr);
    reg_check(3'd4, hr);
    w = (wr == 0) ? 1 : (wr > gbl_pkg::GBL_MAX_WIDTH ? gbl_pkg::GBL_MAX_WIDTH : wr);
    h = (hr == 0) ? 1 : (hr > gbl_pkg::GBL_MAX_HEIGHT ? gbl_pkg::GBL_MAX_HEIGHT : hr);
    total = w * h;
    n = (cut > 0 && cut < total) ? cut : total;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_rand(gbl_pkg::REQ_FLUSH);
      if (style == 1) begin
        v = (i % 2) ? 8'hFF : 8'h00;
        send_item(gbl_pkg::REQ_PIXEL, v, ~v, v);
      end else if (style == 2) begin
        send_item(gbl_pkg::REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      end else begin
        send_rand(gbl_pkg::REQ_PIXEL);
      end
      sent_px++;
    end
    if (n == total) begin
      tail = (total < 2 * w + 2) ? total : 2 * w + 2;
      for (int i = 0; i < tail; i++)
        send_rand($urandom_range(0, 3) == 0 ? gbl_pkg::REQ_PIXEL : gbl_pkg::REQ_FLUSH);
      if ($urandom_range(0, 2) == 0) send_rand(gbl_pkg::REQ_FLUSH);
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pix_ch.valid = 1'b0; pix_ch.req_type = gbl_pkg::REQ_PIXEL;
    pix_ch.red = '0; pix_ch.green = '0; pix_ch.blue = '0;
    bench_fails = 0;
    sent_px = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: tiny and degenerate frames, flat extremes, early flushes
    send_rand(gbl_pkg::REQ_FLUSH);
    run_frame(1, 1, 0, 0);
    run_frame(4, 5, 0, 0);
    run_frame(5, 4, 0, 0);
    run_frame(5, 5, 0, 2);
    run_frame(6, 6, 0, 1);
    run_frame(7, 6, 20, 0);
    run_frame(0, 0, 0, 0);

    // Random frames, mostly small, some unfinished
    while (sent_px < 550) begin
      calm = ($urandom_range(0, 3) == 0);
      run_frame($urandom_range(5, 14), $urandom_range(5, 9),
                ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : 0, 0);
    end
    calm = 1'b0;

    // Largest sizes, saturated from oversize register values, cut short
    run_frame(4095, 5, 80, 0);
    run_frame(0, 8191, 80, 0);
    run_frame(2048, 6, 80, 0);

    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (chk_fails == 0 && bench_fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/gbl_pkg.sv
src/gbl_if.sv
src/gbl_line_store.sv
src/gbl_lane.sv
src/gbl_merge.sv
src/gaussian_blur_5x5_rgb.sv
bench/gbl_checker.sv
bench/tb.sv
